FILE: design/u16w8_pkg.sv
// Shared types, constants and the code point encoder for the UTF-16LE to WTF-8 transcoder.
`default_nettype none
package u16w8_pkg;

    localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LO_TAG = 6'b110111;
    localparam logic [7:0]  UNDERSCORE  = 8'h5F;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;
    localparam logic [20:0] CP_1B_LIM   = 21'h000080;
    localparam logic [20:0] CP_2B_LIM   = 21'h000800;
    localparam logic [20:0] CP_3B_LIM   = 21'h010000;
    localparam logic [7:0]  LEAD_2B     = 8'hC0;
    localparam logic [7:0]  LEAD_3B     = 8'hE0;
    localparam logic [7:0]  LEAD_4B     = 8'hF0;
    localparam logic [7:0]  CONT_TAG    = 8'h80;
    localparam int unsigned MAX_BYTES   = 6;

    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
    } enc_t;

    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic [2:0]                count;
        logic [MAX_BYTES-1:0][7:0] bytes;
    } res_t;

    function automatic enc_t encode_cp(input logic [20:0] cp);
        enc_t e;
        e = '0;
        if (cp < CP_1B_LIM) begin
            e.n    = 3'd1;
            e.b[0] = cp[7:0];
        end else if (cp < CP_2B_LIM) begin
            e.n    = 3'd2;
            e.b[0] = LEAD_2B | {3'b000, cp[10:6]};
            e.b[1] = CONT_TAG | {2'b00, cp[5:0]};
        end else if (cp < CP_3B_LIM) begin
            e.n    = 3'd3;
            e.b[0] = LEAD_3B | {4'b0000, cp[15:12]};
            e.b[1] = CONT_TAG | {2'b00, cp[11:6]};
            e.b[2] = CONT_TAG | {2'b00, cp[5:0]};
        end else begin
            e.n    = 3'd4;
            e.b[0] = LEAD_4B | {5'b00000, cp[20:18]};
            e.b[1] = CONT_TAG | {2'b00, cp[17:12]};
            e.b[2] = CONT_TAG | {2'b00, cp[11:6]};
            e.b[3] = CONT_TAG | {2'b00, cp[5:0]};
        end
        return e;
    endfunction

endpackage
`default_nettype wire

FILE: design/u16w8_decode.sv
// Input register, surrogate tracking state and byte sequence decode.
`default_nettype none
module u16w8_decode
    import u16w8_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_in_last,
    input  wire logic       buf_free,
    output res_t            res
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic [7:0] held_reg, held_next;
    logic       phase_reg, phase_next;
    logic [9:0] pend_reg, pend_next;
    logic       pv_reg, pv_next;

    logic        advance;
    logic [15:0] unit;
    logic        is_hi;
    logic        is_lo;
    logic        flush;
    enc_t        main_enc;
    enc_t        flush_enc;

    assign advance = in_valid_reg && buf_free;
    assign s_ready = !in_valid_reg || advance;
    assign in_valid_next = s_ready ? s_valid : in_valid_reg;

    assign unit  = {in_byte_reg, held_reg};
    assign is_hi = (unit[15:10] == SURR_HI_TAG);
    assign is_lo = (unit[15:10] == SURR_LO_TAG);
    assign flush_enc = encode_cp({5'b00000, SURR_HI_TAG, pend_reg});

    always_comb begin
        held_next  = held_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        pv_next    = pv_reg;
        flush      = 1'b0;
        main_enc   = '0;
        case (phase_reg)
            1'b0: begin
                if (!in_last_reg) begin
                    held_next  = in_byte_reg;
                    phase_next = 1'b1;
                end else begin
                    flush         = pv_reg;
                    main_enc.n    = 3'd1;
                    main_enc.b[0] = UNDERSCORE;
                end
            end
            1'b1: begin
                phase_next = 1'b0;
                held_next  = '0;
                pend_next  = '0;
                pv_next    = 1'b0;
                if (pv_reg && is_lo) begin
                    main_enc = encode_cp(SUPP_BASE + {1'b0, pend_reg, unit[9:0]});
                end else begin
                    flush = pv_reg;
                    if (is_hi && !in_last_reg) begin
                        pend_next = unit[9:0];
                        pv_next   = 1'b1;
                    end else begin
                        main_enc = encode_cp({5'b00000, unit});
                    end
                end
            end
            default: begin
                phase_next = 1'b0;
            end
        endcase
        if (in_last_reg) begin
            held_next  = '0;
            phase_next = 1'b0;
            pend_next  = '0;
            pv_next    = 1'b0;
        end
    end

    always_comb begin
        res       = '0;
        res.valid = advance;
        res.last  = in_last_reg;
        if (flush) begin
            res.bytes[2:0] = flush_enc.b[2:0];
            res.bytes[5:3] = main_enc.b[2:0];
            res.count      = 3'd3 + main_enc.n;
        end else begin
            res.bytes[3:0] = main_enc.b;
            res.count      = main_enc.n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            held_reg     <= '0;
            phase_reg    <= 1'b0;
            pend_reg     <= '0;
            pv_reg       <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                held_reg  <= held_next;
                phase_reg <= phase_next;
                pend_reg  <= pend_next;
                pv_reg    <= pv_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_in_last;
        end
    end

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (!phase_reg && !pv_reg))
        else $error("state not cleared after end of string");

    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |-> (res.count != 3'd0))
        else $error("end of string produced no output byte");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> (res.count <= 3'(MAX_BYTES)))
        else $error("decode count out of range");

endmodule
`default_nettype wire

FILE: design/u16w8_outbuf.sv
// Result shift buffer that drains decoded bytes one transfer per cycle while m_ready is high.
`default_nettype none
module u16w8_outbuf
    import u16w8_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  res_t            res,
    output logic            buf_free,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_out_last
);

    logic [MAX_BYTES-1:0][7:0] bytes_reg, bytes_next;
    logic [2:0]                cnt_reg, cnt_next;
    logic                      last_reg, last_next;
    logic                      xfer;

    assign m_valid    = (cnt_reg != 3'd0);
    assign xfer       = m_valid && m_ready;
    assign buf_free   = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_ready);
    assign m_out_byte = bytes_reg[0];
    assign m_out_last = last_reg && (cnt_reg == 3'd1);

    always_comb begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        if (xfer) begin
            bytes_next = bytes_reg >> 8;
            cnt_next   = cnt_reg - 3'd1;
        end
        if (res.valid && (res.count != 3'd0)) begin
            bytes_next = res.bytes;
            cnt_next   = res.count;
            last_next  = res.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            last_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> buf_free)
        else $error("result loaded over undrained bytes");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(MAX_BYTES))
        else $error("buffer count out of range");

    a_drain_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer && !res.valid && (cnt_reg > 3'd1)) |=> (cnt_reg == $past(cnt_reg) - 3'd1))
        else $error("buffer count did not advance on transfer");

endmodule
`default_nettype wire

FILE: design/utf16le_to_wtf8_transcoder.sv
// Top level of the UTF-16LE to WTF-8 transcoder.
// Path: an input byte is held in the decode input register, and the bytes it yields are
// loaded into the result buffer, which drives the output stream.
// Throughput: one input byte per cycle while the result buffer can take a result; output runs at
// one byte per cycle while m_ready is high, and an item yields up to 6 bytes in the result buffer.
// Reset (aresetn low, synchronous) clears the input stage, the surrogate and byte
// pairing state, and the result buffer; no output is valid after reset.
`default_nettype none
module utf16le_to_wtf8_transcoder
    import u16w8_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_in_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_out_last
);

    res_t res;
    logic buf_free;

    u16w8_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .buf_free  (buf_free),
        .res       (res)
    );

    u16w8_outbuf u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .res        (res),
        .buf_free   (buf_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule
`default_nettype wire

FILE: sim/utf16le_to_wtf8_transcoder_tb.sv
// Self-checking testbench: UTF-16LE byte strings in, predicted WTF-8 bytes compared on the output.
`default_nettype none
module utf16le_to_wtf8_transcoder_tb;

    localparam logic [5:0]  HI_SURR_TAG   = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG   = 6'b110111;
    localparam logic [7:0]  ODD_TAIL_MARK = 8'h5F;
    localparam logic [20:0] SUPP_PLANE    = 21'h010000;
    localparam int          RANDOM_BYTES  = 430;

    typedef enum logic [1:0] {FREE_FLOW, SEND_SPARSE, SINK_STALLED, BOTH_SPARSE} flow_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        flow_t      flow;
    } utf16_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } wtf8_byte_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       s_in_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_out_last;

    utf16_byte_t utf16_bytes[$];
    wtf8_byte_t  wtf8_expected[$];
    logic [7:0]  wtf8_scratch[$];

    int unsigned send_idle_pct[4] = '{0, 82, 0, 11};
    int unsigned sink_stall_pct[4] = '{0, 0, 82, 11};
    flow_t       cur_flow = FREE_FLOW;
    flow_t       stim_flow = FREE_FLOW;

    logic [7:0] lo_byte_q = 8'h00;
    logic       hi_phase_q = 1'b0;
    logic [9:0] held_surr_q = 10'h000;
    logic       surr_held_q = 1'b0;

    int errors = 0;
    int bytes_in = 0;
    int bytes_out = 0;
    int strings_done = 0;
    int pairs_joined = 0;
    int odd_tails = 0;
    int queued = 0;

    utf16le_to_wtf8_transcoder u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    always #1 aclk = ~aclk;

    function automatic void add_wtf8(input logic [7:0] b);
        wtf8_scratch.insert(wtf8_scratch.size(), b);
    endfunction

    function automatic void append_code_point(input logic [20:0] cp);
        if (cp < 21'h000080) begin
            add_wtf8(cp[7:0]);
        end else if (cp < 21'h000800) begin
            add_wtf8({3'b110, cp[10:6]});
            add_wtf8({2'b10, cp[5:0]});
        end else if (cp < 21'h010000) begin
            add_wtf8({4'b1110, cp[15:12]});
            add_wtf8({2'b10, cp[11:6]});
            add_wtf8({2'b10, cp[5:0]});
        end else begin
            add_wtf8({5'b11110, cp[20:18]});
            add_wtf8({2'b10, cp[17:12]});
            add_wtf8({2'b10, cp[11:6]});
            add_wtf8({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void flush_held_surrogate();
        if (surr_held_q) begin
            append_code_point({5'b00000, HI_SURR_TAG, held_surr_q});
            surr_held_q = 1'b0;
            held_surr_q = '0;
        end
    endfunction

    function automatic void predict_wtf8(input logic [7:0] b, input logic last);
        logic [15:0] unit;
        wtf8_scratch.delete();
        if (!hi_phase_q) begin
            if (!last) begin
                lo_byte_q = b;
                hi_phase_q = 1'b1;
                return;
            end
            flush_held_surrogate();
            add_wtf8(ODD_TAIL_MARK);
            odd_tails++;
        end else begin
            unit = {b, lo_byte_q};
            hi_phase_q = 1'b0;
            lo_byte_q = '0;
            if (surr_held_q && unit[15:10] == LO_SURR_TAG) begin
                append_code_point(SUPP_PLANE + {1'b0, held_surr_q, unit[9:0]});
                surr_held_q = 1'b0;
                held_surr_q = '0;
                pairs_joined++;
            end else begin
                flush_held_surrogate();
                if (unit[15:10] == HI_SURR_TAG && !last) begin
                    held_surr_q = unit[9:0];
                    surr_held_q = 1'b1;
                end else begin
                    append_code_point({5'b00000, unit});
                end
            end
        end
        foreach (wtf8_scratch[i]) begin
            wtf8_expected.insert(wtf8_expected.size(),
                '{wtf8_scratch[i], last && (i == wtf8_scratch.size() - 1)});
        end
        if (last) begin
            lo_byte_q = '0;
            hi_phase_q = 1'b0;
            held_surr_q = '0;
            surr_held_q = 1'b0;
            strings_done++;
        end
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic last);
        utf16_bytes.insert(utf16_bytes.size(), '{b, last, stim_flow});
        queued++;
    endtask

    task automatic queue_unit(input logic [15:0] u, input logic last);
        queue_byte(u[7:0], 1'b0);
        queue_byte(u[15:8], last);
    endtask

    always @(posedge aclk) begin : drive
        utf16_byte_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_wtf8(s_in_byte, s_in_last);
                bytes_in++;
            end
            if (!s_valid || s_ready) begin
                if (utf16_bytes.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct[int'(cur_flow)]) begin
                    item = utf16_bytes.pop_front();
                    cur_flow <= item.flow;
                    s_in_byte <= item.data;
                    s_in_last <= item.last;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : observe
        wtf8_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (wtf8_expected.size() == 0) begin
                $display("%0t: unexpected output, expected none, got byte %02h last %0b",
                         $time, m_out_byte, m_out_last);
                errors++;
            end else begin
                want = wtf8_expected.pop_front();
                if (m_out_byte !== want.data || m_out_last !== want.last) begin
                    $display("%0t: mismatch, expected byte %02h last %0b, got byte %02h last %0b",
                             $time, want.data, want.last, m_out_byte, m_out_last);
                    errors++;
                end
            end
            bytes_out++;
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct[int'(cur_flow)]);
    end

    initial begin : stimulus
        logic [15:0] units[$];
        int          n_units;
        bit          odd_tail;

        queue_unit(16'h0000, 1'b0);
        queue_unit(16'h007F, 1'b0);
        queue_unit(16'h0080, 1'b0);
        queue_unit(16'h07FF, 1'b0);
        queue_unit(16'h0800, 1'b0);
        queue_unit(16'hFFFF, 1'b1);
        queue_unit(16'hD800, 1'b0);
        queue_unit(16'hDC00, 1'b0);
        queue_unit(16'hDBFF, 1'b0);
        queue_unit(16'hDFFF, 1'b1);
        queue_unit(16'hD800, 1'b0);
        queue_unit(16'h0041, 1'b0);
        queue_unit(16'hDC00, 1'b1);
        queue_unit(16'hD800, 1'b0);
        queue_unit(16'hDBFF, 1'b1);
        queue_unit(16'hD800, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);

        while (queued < RANDOM_BYTES) begin
            stim_flow = flow_t'((queued / 40) % 4);
            units.delete();
            n_units = $urandom_range(0, 6);
            odd_tail = ($urandom_range(3) == 0);
            if (n_units == 0) begin
                odd_tail = 1'b1;
            end
            repeat (n_units) begin
                case ($urandom_range(9))
                    0, 1: units.insert(units.size(), 16'($urandom_range(16'h007F)));
                    2: units.insert(units.size(), 16'($urandom_range(16'h0080, 16'h07FF)));
                    3: units.insert(units.size(), 16'($urandom_range(16'h0800, 16'hFFFF)));
                    4, 5: begin
                        units.insert(units.size(), {HI_SURR_TAG, 10'($urandom)});
                        units.insert(units.size(), {LO_SURR_TAG, 10'($urandom)});
                    end
                    6: units.insert(units.size(), {HI_SURR_TAG, 10'($urandom)});
                    7: units.insert(units.size(), {LO_SURR_TAG, 10'($urandom)});
                    default: units.insert(units.size(), 16'($urandom));
                endcase
            end
            foreach (units[i]) begin
                queue_unit(units[i], !odd_tail && (i == units.size() - 1));
            end
            if (odd_tail) begin
                queue_byte(8'($urandom), 1'b1);
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        while (utf16_bytes.size() != 0 || s_valid) @(posedge aclk);
        while (wtf8_expected.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("Sent %0d UTF-16LE bytes in %0d strings; checked %0d WTF-8 bytes.",
                 bytes_in, strings_done, bytes_out);
        $display("Joined %0d surrogate pairs, closed %0d strings on an odd byte, %0d errors.",
                 pairs_joined, odd_tails, errors);
        if (errors == 0 && wtf8_expected.size() == 0) begin
            $display("utf16le_to_wtf8_transcoder regression: pass");
        end else begin
            $display("utf16le_to_wtf8_transcoder regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("Timed out with %0d input bytes and %0d output bytes outstanding.",
                 utf16_bytes.size(), wtf8_expected.size());
        $display("utf16le_to_wtf8_transcoder regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

FILE: utf16le_to_wtf8_transcoder.f
design/u16w8_pkg.sv
design/u16w8_decode.sv
design/u16w8_outbuf.sv
design/utf16le_to_wtf8_transcoder.sv
sim/utf16le_to_wtf8_transcoder_tb.sv
